### design/lkvc_pkg.sv
package lkvc_pkg;

   localparam int ENTRIES_DEF    = 8;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int CAP_BITS = 4;
   localparam int OCC_BITS = 4;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic hit;
      logic evicted;
   } lkvc_flags_type;

endpackage

### design/lkvc_store.sv
module lkvc_store import lkvc_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_kind_type          kind,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [CAP_BITS-1:0]   capacity,
   output lkvc_flags_type        flags,
   output logic [VALUE_BITS-1:0] read_value,
   output logic [KEY_BITS-1:0]   evicted_key,
   output logic [OCC_BITS-1:0]   occupancy
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [KEY_BITS-1:0]   key_in   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [RANK_W-1:0]     rank_ff  [ENTRIES];
   logic [RANK_W-1:0]     rank_in  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    valid_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    victim;
   logic [ENTRIES-1:0]    free_oh;
   logic [ENTRIES-1:0]    ins_oh;
   logic [RANK_W-1:0]     hit_rank;
   logic [VALUE_BITS-1:0] hit_value;
   logic [KEY_BITS-1:0]   victim_key;
   logic [CNT_W-1:0]      count_m1;
   logic [CAP_BITS-1:0]   cap_nz;
   logic [CMP_W-1:0]      eff_cap;
   logic                  found;
   logic                  is_put;
   logic                  full;
   logic                  do_insert;
   logic                  do_evict;

   // least recent valid entry always holds rank count-1
   assign count_m1 = count_ff - CNT_W'(1);

   always_comb begin
      match      = '0;
      victim     = '0;
      hit_rank   = '0;
      hit_value  = '0;
      victim_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == key);
         victim[i] = valid_ff[i] && (rank_ff[i] == RANK_W'(count_m1));
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
         if (victim[i]) begin
            victim_key = victim_key | key_ff[i];
         end
      end
   end

   // lowest free slot
   assign free_oh = ~valid_ff & (valid_ff + ENTRIES'(1));

   assign cap_nz  = (capacity == '0) ? CAP_BITS'(1) : capacity;
   assign eff_cap = (CMP_W'(cap_nz) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_nz);
   assign full    = ((CMP_W'(count_ff) + CMP_W'(1)) > eff_cap)
                    || (CMP_W'(count_ff) >= CMP_W'(ENTRIES));

   assign found     = |match;
   assign is_put    = (kind == REQ_PUT);
   assign do_insert = fire && is_put && !found;
   assign do_evict  = do_insert && full;
   assign ins_oh    = do_evict ? victim : free_oh;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         if (fire && found) begin
            if (match[i]) begin
               rank_in[i] = '0;
               if (is_put) begin
                  value_in[i] = value;
               end
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end else if (do_insert) begin
            if (ins_oh[i]) begin
               key_in[i]   = key;
               value_in[i] = value;
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      count_in = (do_insert && !do_evict) ? count_ff + CNT_W'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   assign flags.hit     = found;
   assign flags.evicted = do_evict;
   assign read_value    = (found && !is_put) ? hit_value : '0;
   assign evicted_key   = do_evict ? victim_key : '0;
   assign occupancy     = OCC_BITS'(count_in);

endmodule

### design/lru_key_value_cache_top.sv
// channel  | direction | handshake            | payload
// req_     | in        | req_valid/req_stall  | type, lookup_key, write_value
// rsp_     | out       | rsp_valid/rsp_stall  | hit, read_value, evicted, evicted_key, occupancy
// csr_     | in        | csr_valid/csr_ready  | capacity_in_use
//
// one request per cycle sustained while rsp_stall is low; a request is registered on transfer and its
// result is registered in the result register, which drives rsp, once that register is free or being emptied
// the whole key compare and rank update are combinational logic between the two registers
// reset clears valid bits, ranks and the entry count together; no clearing sweep
// rsp_stall holds the result register, and req_stall rises only while a request waits behind it
module lru_key_value_cache_top import lkvc_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [KEY_BITS-1:0]   req_lookup_key,
   input  logic [VALUE_BITS-1:0] req_write_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key,
   output logic [OCC_BITS-1:0]   rsp_occupancy,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_BITS-1:0]   csr_capacity_in_use
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_kind_type          in_kind_ff;
   logic [KEY_BITS-1:0]   in_key_ff;
   logic [VALUE_BITS-1:0] in_value_ff;
   logic                  in_load;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   lkvc_flags_type        out_flags_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic [KEY_BITS-1:0]   out_ev_key_ff;
   logic [OCC_BITS-1:0]   out_occ_ff;

   logic [CAP_BITS-1:0]   cap_ff;
   logic [CAP_BITS-1:0]   cap_in;

   logic                  advance;
   lkvc_flags_type        st_flags;
   logic [VALUE_BITS-1:0] st_value;
   logic [KEY_BITS-1:0]   st_ev_key;
   logic [OCC_BITS-1:0]   st_occ;

   // result register free or being emptied this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = !req_stall;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_capacity_in_use : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_kind_ff  <= req_kind_type'(req_type);
         in_key_ff   <= req_lookup_key;
         in_value_ff <= req_write_value;
      end
      if (advance) begin
         out_flags_ff  <= st_flags;
         out_value_ff  <= st_value;
         out_ev_key_ff <= st_ev_key;
         out_occ_ff    <= st_occ;
      end
   end

   lkvc_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .kind        (in_kind_ff),
      .key         (in_key_ff),
      .value       (in_value_ff),
      .capacity    (cap_ff),
      .flags       (st_flags),
      .read_value  (st_value),
      .evicted_key (st_ev_key),
      .occupancy   (st_occ)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit         = out_flags_ff.hit;
   assign rsp_evicted     = out_flags_ff.evicted;
   assign rsp_read_value  = out_value_ff;
   assign rsp_evicted_key = out_ev_key_ff;
   assign rsp_occupancy   = out_occ_ff;

endmodule

### design/lkvc_checker.sv
module lkvc_checker import lkvc_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_hit,
   input logic [VALUE_BITS-1:0] rsp_read_value,
   input logic                  rsp_evicted,
   input logic [KEY_BITS-1:0]   rsp_evicted_key,
   input logic [OCC_BITS-1:0]   rsp_occupancy
);

   // stalled result transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted)
         && $stable(rsp_read_value) && $stable(rsp_evicted_key) && $stable(rsp_occupancy))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("handshake not cleared by reset");

   // an eviction only happens on a put of a new key, never with a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_read_value == '0)
         && (rsp_occupancy != '0))
      else $error("eviction together with hit or empty store");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key without eviction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0)
      else $error("read value without hit");

endmodule

bind lru_key_value_cache_top lkvc_checker #(
   .KEY_BITS   (KEY_BITS),
   .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key),
   .rsp_occupancy   (rsp_occupancy)
);

### tb/sv/lru_cache_tb_pkg.sv
package lru_cache_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int SLOTS = ENTRIES_DEF;

   typedef logic [KEY_BITS_DEF-1:0]   key_type;
   typedef logic [VALUE_BITS_DEF-1:0] value_type;

   typedef struct packed {
      logic                hit;
      value_type           read_value;
      logic                evicted;
      key_type             evicted_key;
      logic [OCC_BITS-1:0] occupancy;
   } cache_response_type;

   // mirror of the store; predicts one response per accepted request
   class cache_shadow;
      key_type             slot_key[SLOTS];
      value_type           slot_value[SLOTS];
      bit                  slot_valid[SLOTS];
      int unsigned         slot_rank[SLOTS];
      int unsigned         live_count;
      logic [CAP_BITS-1:0] capacity;
      cache_response_type  expected_responses[$];
      int unsigned         mismatches;
      int unsigned         requests;
      int unsigned         hits;
      int unsigned         evictions;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
         end
         live_count = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
         requests   = 0;
         hits       = 0;
         evictions  = 0;
      endfunction

      function void set_capacity(logic [CAP_BITS-1:0] cap);
         capacity = cap;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      // every valid entry more recent than limit gets one step older
      function void age_slots(int unsigned limit, int skip);
         for (int i = 0; i < SLOTS; i++) begin
            if (i != skip && slot_valid[i] && slot_rank[i] < limit)
               slot_rank[i]++;
         end
      endfunction

      function void note_request(req_kind_type kind, key_type key, value_type value);
         cache_response_type rsp;
         int                 found;
         int                 slot;
         int unsigned        cap;
         int unsigned        oldest;
         rsp    = '0;
         found  = -1;
         slot   = -1;
         oldest = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key)
               found = i;
         end
         if (found >= 0) begin
            rsp.hit = 1'b1;
            if (kind == REQ_GET)
               rsp.read_value = slot_value[found];
            else
               slot_value[found] = value;
            age_slots(slot_rank[found], found);
            slot_rank[found] = 0;
         end else if (kind == REQ_PUT) begin
            cap = 32'(capacity);
            if (cap == 0)
               cap = 1;
            if (cap > SLOTS)
               cap = SLOTS;
            if (live_count + 1 > cap || live_count >= SLOTS) begin
               // ties go to the highest slot holding the oldest rank
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i] && (slot < 0 || slot_rank[i] >= oldest)) begin
                     slot   = i;
                     oldest = slot_rank[i];
                  end
               end
               if (slot >= 0) begin
                  rsp.evicted     = 1'b1;
                  rsp.evicted_key = slot_key[slot];
                  slot_valid[slot] = 1'b0;
                  live_count--;
               end
            end
            if (slot < 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot < 0 && !slot_valid[i])
                     slot = i;
               end
            end
            if (slot >= 0) begin
               age_slots(32'hFFFF_FFFF, slot);
               slot_key[slot]   = key;
               slot_value[slot] = value;
               slot_valid[slot] = 1'b1;
               slot_rank[slot]  = 0;
               live_count++;
            end
         end
         rsp.occupancy = OCC_BITS'(live_count);
         requests++;
         if (rsp.hit)
            hits++;
         if (rsp.evicted)
            evictions++;
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(cache_response_type got);
         cache_response_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t ns: response with none outstanding, expected nothing, actual %0h",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("hit", 64'(want.hit), 64'(got.hit));
         compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
         compare_field("evicted", 64'(want.evicted), 64'(got.evicted));
         compare_field("evicted_key", 64'(want.evicted_key), 64'(got.evicted_key));
         compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
      endfunction
   endclass

endpackage

### tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;
   import lru_cache_tb_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int IDLE_LIMIT  = 1000;
   localparam int LONG_HOLD   = 150;
   localparam int PHASE_ITEMS = 75;
   localparam int PHASES      = 8;
   localparam int POOL_KEYS   = 16;

   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                req_valid           = 1'b0;
   logic                req_type            = 1'b0;
   key_type             req_lookup_key      = '0;
   value_type           req_write_value     = '0;
   logic                rsp_stall           = 1'b0;
   logic                csr_valid           = 1'b0;
   logic [CAP_BITS-1:0] csr_capacity_in_use = CAP_RESET;

   logic                req_stall;
   logic                rsp_valid;
   logic                rsp_hit;
   value_type           rsp_read_value;
   logic                rsp_evicted;
   key_type             rsp_evicted_key;
   logic [OCC_BITS-1:0] rsp_occupancy;
   logic                csr_ready;

   cache_shadow         shadow = new();
   key_type             key_pool[POOL_KEYS];
   bit                  sender_idles   = 1'b0;
   bit                  receiver_idles = 1'b0;
   int unsigned         long_hold      = 0;
   int unsigned         quiet_cycles   = 0;

   // zero and above-range capacities included, and a drop to 2 while full
   logic [CAP_BITS-1:0] phase_caps[PHASES] = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd8, 4'd2, 4'd5, 4'd8};

   lru_key_value_cache_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_lookup_key      (req_lookup_key),
      .req_write_value     (req_write_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_key     (rsp_evicted_key),
      .rsp_occupancy       (rsp_occupancy),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random hold-off before each transfer while receiver_idles is set, or one long hold
   initial begin
      int unsigned        hold;
      cache_response_type got;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold != 0) begin
            hold      = long_hold;
            long_hold = 0;
         end else begin
            hold = receiver_idles ? $urandom_range(0, 14) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got = '{hit: rsp_hit, read_value: rsp_read_value, evicted: rsp_evicted,
                 evicted_key: rsp_evicted_key, occupancy: rsp_occupancy};
         shadow.check_response(got);
         @(negedge clock);
      end
   end

   // valid stays high between back-to-back requests
   task automatic send_request(req_kind_type kind, key_type key, value_type value);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_lookup_key  <= key;
      req_write_value <= value;
      do @(posedge clock); while (req_stall);
      shadow.note_request(kind, key, value);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= cap;
      do @(posedge clock); while (!csr_ready);
      shadow.set_capacity(cap);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned  eff_cap;
      req_kind_type kind;
      key_type      key;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_KEYS; i++)
         key_pool[i] = $urandom();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_capacity(4'd8);
      send_request(REQ_GET, '0, '1);             // miss on an empty store
      send_request(REQ_PUT, '0, '1);
      send_request(REQ_PUT, '1, '0);
      send_request(REQ_GET, '0, '0);
      send_request(REQ_GET, '1, '1);
      send_request(REQ_PUT, '0, 32'h5a5a_a5a5);  // update in place
      // fill the store, then one more insert pushes out the all-ones key
      for (int i = 2; i <= 8; i++)
         send_request(REQ_PUT, key_pool[i], value_type'(i * 32'h1111_1111));
      send_request(REQ_GET, '1, '0);
      send_request(REQ_GET, key_pool[2], '1);
      send_request(REQ_PUT, key_pool[9], $urandom());
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         sender_idles   = phase[0];
         receiver_idles = phase[1];
         if (phase == 2) begin
            // back-pressure: results held while requests keep coming
            sender_idles = 1'b0;
            long_hold    = LONG_HOLD;
         end
         eff_cap = 32'(phase_caps[phase]);
         if (eff_cap == 0)
            eff_cap = 1;
         if (eff_cap > SLOTS)
            eff_cap = SLOTS;
         repeat (PHASE_ITEMS) begin
            kind = ($urandom_range(0, 99) < 55) ? REQ_PUT : REQ_GET;
            if ($urandom_range(0, 9) == 0)
               key = $urandom();
            else
               key = key_pool[$urandom_range(0, eff_cap + 2)];
            send_request(kind, key, $urandom());
         end
         drain();
      end

      $display("run covered %0d requests with %0d hits and %0d evictions,",
               shadow.requests, shadow.hits, shadow.evictions);
      $display("over capacities 1 to 8 plus zero and above range, with stalls on both sides");
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
design/lkvc_pkg.sv
design/lkvc_store.sv
design/lru_key_value_cache_top.sv
design/lkvc_checker.sv
tb/sv/lru_cache_tb_pkg.sv
tb/sv/tb_top.sv
